/* hw/rtl/enfa_pkg.sv */
// Package for the epsilon-NFA conversion engine: field structs, op codes,
// sequencer states and sizing constants. No dependencies.
package enfa_pkg;

    localparam int NUM_STATES_DEF  = 16;
    localparam int NUM_SYMBOLS_DEF = 26;
    localparam int STATE_W  = 4;
    localparam int SYM_W    = 5;
    localparam int SET_W    = 16;
    localparam logic [SYM_W-1:0] EPS_RESET = 5'd4;

    typedef enum logic [2:0] {
        OP_CLEAR   = 3'd0,
        OP_ADD     = 3'd1,
        OP_FINAL   = 3'd2,
        OP_CLOSURE = 3'd3,
        OP_QUERY   = 3'd4
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_CLR,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_CI,
        ST_CK,
        ST_QM,
        ST_QN,
        ST_QDONE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [2:0]         operation;
        logic [STATE_W-1:0] from_state;
        logic [SYM_W-1:0]   symbol;
        logic [STATE_W-1:0] to_state;
    } cmd_t;

    typedef struct packed {
        logic [SET_W-1:0] next_set;
        logic [SET_W-1:0] closure_set;
        logic             accepting;
    } rsp_t;

endpackage

/* hw/rtl/enfa_ram.sv */
// Generic single-port synchronous RAM with registered read.
// No dependencies.
module enfa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

/* hw/rtl/epsilon_nfa_conversion_engine.sv */
// Top level of the epsilon-NFA conversion engine: sequencer, small tables,
// move-table RAM. Depends on enfa_pkg and enfa_ram.
//
// Channel  Signals                          Transfer
// cmd      start, busy, cmd                 start && !busy
// rsp      done, rsp                        done high for one cycle
// cfg      psel penable pwrite paddr pwdata psel && penable && pwrite
//
// Steps per command; done strobes in the first cycle after busy drops.
// Mark final and unused codes: done only. Add: read, write back, done.
// Clear: one move-table entry per cycle through the single RAM port, then
// done. Compute closures: one row init per state, then one row OR per cycle
// for each state pair, then done. Query: one move-table read per state, one
// closure fold per state, then done. After reset the same sweep runs with
// busy high and no done. The receiver cannot stall; done is a single-cycle strobe.
module epsilon_nfa_conversion_engine #(
    parameter int NUM_SYMBOLS = enfa_pkg::NUM_SYMBOLS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    output logic         busy,
    input  enfa_pkg::cmd_t cmd,
    output logic         done,
    output enfa_pkg::rsp_t rsp,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [1:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import enfa_pkg::*;

    localparam int NUM_STATES = NUM_STATES_DEF;
    localparam int SW    = $clog2(NUM_STATES);
    localparam int DEPTH = NUM_STATES * NUM_SYMBOLS;
    localparam int AW    = $clog2(DEPTH);

    state_t state_reg, state_next;
    logic [SYM_W-1:0] eps_reg;
    logic [NUM_STATES-1:0] eps_adj_reg [NUM_STATES];
    logic [NUM_STATES-1:0] clo_reg [NUM_STATES];
    logic [NUM_STATES-1:0] final_reg;
    cmd_t cmd_reg;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic [SW-1:0] i_reg, k_reg;
    logic [NUM_STATES-1:0] acc_reg;
    rsp_t rsp_reg;
    logic done_reg;

    logic ram_we;
    logic [AW-1:0] ram_addr;
    logic [NUM_STATES-1:0] ram_wdata, ram_rdata;

    logic from_ok, to_ok, sym_ok, is_eps;
    logic [AW-1:0] cell_addr;
    logic [NUM_STATES-1:0] qclo;

    enfa_ram #(.WIDTH(NUM_STATES), .DEPTH(DEPTH)) u_move (
        .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
    );

    assign from_ok = 32'(cmd_reg.from_state) < NUM_STATES;
    assign to_ok   = 32'(cmd_reg.to_state) < NUM_STATES;
    assign is_eps  = cmd_reg.symbol == eps_reg;
    assign sym_ok  = 32'(cmd_reg.symbol) < NUM_SYMBOLS;
    assign cell_addr = AW'(32'(i_reg) * NUM_SYMBOLS + 32'(cmd_reg.symbol));
    assign qclo = clo_reg[cmd_reg.from_state[SW-1:0]];

    assign busy   = state_reg != ST_IDLE;
    assign done   = done_reg;
    assign rsp    = rsp_reg;
    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {27'd0, eps_reg} : 32'd0;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (cmd.operation)
                        OP_CLEAR:   state_next = ST_CLR;
                        OP_ADD:     state_next = ST_ADD_RD;
                        OP_CLOSURE: state_next = ST_CI;
                        OP_QUERY:   state_next = ST_QM;
                        default:    state_next = ST_DONE;
                    endcase
                end
            end
            ST_INIT:   if (32'(cnt_reg) == DEPTH - 1) state_next = ST_IDLE;
            ST_CLR:    if (32'(cnt_reg) == DEPTH - 1) state_next = ST_DONE;
            ST_ADD_RD: state_next = ST_ADD_WR;
            ST_ADD_WR: state_next = ST_DONE;
            ST_CI:     if (32'(i_reg) == NUM_STATES - 1) state_next = ST_CK;
            ST_CK:
            begin
                if (32'(i_reg) == NUM_STATES - 1 && 32'(k_reg) == NUM_STATES - 1)
                    state_next = ST_DONE;
            end
            ST_QM:     if (32'(i_reg) == NUM_STATES - 1) state_next = ST_QN;
            ST_QN:     if (32'(i_reg) == NUM_STATES - 1) state_next = ST_QDONE;
            ST_QDONE:  state_next = ST_IDLE;
            ST_DONE:   state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // RAM port control
    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = cell_addr;
        ram_wdata = ram_rdata;
        cnt_next  = cnt_reg;
        unique case (state_reg)
            ST_INIT, ST_CLR:
            begin
                ram_we    = 1'b1;
                ram_addr  = cnt_reg;
                ram_wdata = '0;
                cnt_next  = cnt_reg + AW'(1);
            end
            ST_ADD_WR:
            begin
                ram_we = from_ok && to_ok && !is_eps && sym_ok;
                ram_wdata = ram_rdata | (NUM_STATES'(1) << cmd_reg.to_state);
            end
            default: cnt_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            cnt_reg   <= '0;
            i_reg     <= '0;
            k_reg     <= '0;
            done_reg  <= 1'b0;
            eps_reg   <= EPS_RESET;
            final_reg <= '0;
            cmd_reg   <= '0;
            acc_reg   <= '0;
            rsp_reg   <= '0;
            for (int s = 0; s < NUM_STATES; s++)
            begin
                eps_adj_reg[s] <= '0;
                clo_reg[s]     <= NUM_STATES'(1) << s;
            end
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= 1'b0;
            if (psel && penable && pwrite && paddr == 2'd0)
                eps_reg <= pwdata[SYM_W-1:0];
            unique case (state_reg)
                ST_IDLE:
                begin
                    // an add reads its own row next cycle
                    if (start && cmd.operation == OP_ADD)
                        i_reg <= cmd.from_state[SW-1:0];
                    else
                        i_reg <= '0;
                    k_reg <= '0;
                    if (start)
                    begin
                        if (cmd.operation == OP_CLEAR)
                        begin
                            final_reg <= '0;
                            for (int s = 0; s < NUM_STATES; s++)
                            begin
                                eps_adj_reg[s] <= '0;
                                clo_reg[s]     <= NUM_STATES'(1) << s;
                            end
                        end
                        if (cmd.operation == OP_FINAL && 32'(cmd.from_state) < NUM_STATES)
                            final_reg[cmd.from_state[SW-1:0]] <= 1'b1;
                    end
                end
                ST_ADD_RD:
                begin
                    if (from_ok && to_ok && is_eps)
                        eps_adj_reg[cmd_reg.from_state[SW-1:0]][cmd_reg.to_state[SW-1:0]]
                            <= 1'b1;
                end
                ST_CI:
                begin
                    clo_reg[i_reg] <= (NUM_STATES'(1) << i_reg) | eps_adj_reg[i_reg];
                    i_reg <= i_reg + SW'(1);
                end
                ST_CK:
                begin
                    if (clo_reg[i_reg][k_reg])
                        clo_reg[i_reg] <= clo_reg[i_reg] | clo_reg[k_reg];
                    i_reg <= i_reg + SW'(1);
                    if (32'(i_reg) == NUM_STATES - 1)
                        k_reg <= k_reg + SW'(1);
                end
                ST_QM:
                begin
                    // read issued for row i; data lands next cycle
                    k_reg <= i_reg;
                    i_reg <= i_reg + SW'(1);
                    if (32'(i_reg) == 0)
                        acc_reg <= '0;
                    else if (qclo[k_reg])
                        acc_reg <= acc_reg | ram_rdata;
                end
                ST_QN:
                begin
                    if (32'(i_reg) == 0)
                    begin
                        if (qclo[k_reg])
                            acc_reg <= acc_reg | ram_rdata;
                        rsp_reg.next_set <= '0;
                    end
                    i_reg <= i_reg + SW'(1);
                end
                default: ;
            endcase
            if (state_reg == ST_IDLE && start)
                cmd_reg <= cmd;
            if (state_reg == ST_DONE)
            begin
                done_reg <= 1'b1;
                rsp_reg  <= '0;
            end
            if (state_reg == ST_QN)
            begin
                // closure of moved set: the last move row folds in on the first step
                if (32'(i_reg) != 0 && acc_reg[i_reg])
                    rsp_reg.next_set <= rsp_reg.next_set | SET_W'(clo_reg[i_reg]);
                if (32'(i_reg) == 0 && (acc_reg[0] || (qclo[k_reg] && ram_rdata[0])))
                    rsp_reg.next_set <= SET_W'(clo_reg[0]);
            end
            if (state_reg == ST_QDONE)
            begin
                done_reg <= 1'b1;
                if (acc_reg[NUM_STATES-1])
                    rsp_reg.next_set <= rsp_reg.next_set | SET_W'(clo_reg[NUM_STATES-1]);
                if (!from_ok || !sym_ok || is_eps)
                    rsp_reg.next_set <= '0;
                rsp_reg.closure_set <= from_ok ? SET_W'(qclo) : '0;
                rsp_reg.accepting   <= from_ok && ((qclo & final_reg) != '0);
            end
        end
    end
endmodule

/* tb/sv/epsilon_nfa_conversion_engine_test.sv */
// Testbench for the epsilon-NFA conversion engine: drives commands, writes the
// epsilon symbol over APB and checks every response against a local predictor.
// Depends on enfa_pkg and the engine RTL.
module epsilon_nfa_conversion_engine_test;
    timeunit 1ns;
    timeprecision 1ps;
    import enfa_pkg::*;

    localparam int NST = 16;
    localparam int NSYM = 26;
    localparam longint CYCLE_LIMIT = 2000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    cmd_t cmd = '0;
    logic done;
    rsp_t rsp;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    epsilon_nfa_conversion_engine i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .done(done), .rsp(rsp), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #2 clk = ~clk;

    // predictor state
    logic [15:0] mv_tab [NST][NSYM];
    logic [15:0] eps_adj [NST];
    logic [15:0] clo_tab [NST];
    logic [15:0] fin_mask;
    logic [4:0] eps_sym;

    rsp_t pending_rsp [$];
    int mismatches = 0;
    int sent = 0;
    int queries = 0;
    int gap_pct = 0;
    longint cycles = 0;

    function automatic void clear_nfa();
        for (int i = 0; i < NST; i++)
        begin
            for (int j = 0; j < NSYM; j++)
                mv_tab[i][j] = '0;
            eps_adj[i] = '0;
            clo_tab[i] = 16'(1) << i;
        end
        fin_mask = '0;
    endfunction

    function automatic rsp_t predict_rsp(cmd_t c);
        rsp_t r;
        logic [15:0] moved;
        r = '0;
        case (c.operation)
            OP_CLEAR: clear_nfa();
            OP_ADD:
                if (c.symbol == eps_sym)
                    eps_adj[c.from_state] |= 16'(1) << c.to_state;
                else if (c.symbol < NSYM)
                    mv_tab[c.from_state][c.symbol] |= 16'(1) << c.to_state;
            OP_FINAL: fin_mask |= 16'(1) << c.from_state;
            OP_CLOSURE:
            begin
                for (int i = 0; i < NST; i++)
                    clo_tab[i] = (16'(1) << i) | eps_adj[i];
                for (int k = 0; k < NST; k++)
                    for (int i = 0; i < NST; i++)
                        if (clo_tab[i][k])
                            clo_tab[i] |= clo_tab[k];
            end
            OP_QUERY:
            begin
                r.closure_set = clo_tab[c.from_state];
                r.accepting = |(r.closure_set & fin_mask);
                if (c.symbol < NSYM && c.symbol != eps_sym)
                begin
                    moved = '0;
                    for (int p = 0; p < NST; p++)
                        if (r.closure_set[p])
                            moved |= mv_tab[p][c.symbol];
                    for (int s = 0; s < NST; s++)
                        if (moved[s])
                            r.next_set |= clo_tab[s];
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // check each response transfer against the oldest expectation
    always @(posedge clk)
    begin
        rsp_t exp_r;
        if (rst_n && done)
        begin
            if (pending_rsp.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response %h", rsp);
            end
            else
            begin
                exp_r = pending_rsp.pop_front();
                if (rsp.next_set !== exp_r.next_set
                    || rsp.closure_set !== exp_r.closure_set
                    || rsp.accepting !== exp_r.accepting)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp next %h clo %h acc %b, got %h %h %b",
                                 exp_r.next_set, exp_r.closure_set, exp_r.accepting,
                                 rsp.next_set, rsp.closure_set, rsp.accepting);
                end
            end
        end
    end

    // busy only changes at rising edges, so a low busy seen at the falling edge
    // means the next rising edge takes the transfer
    task automatic send_cmd(logic [2:0] op, logic [3:0] fs, logic [4:0] sy, logic [3:0] ts);
        cmd_t c;
        c = '{operation: op, from_state: fs, symbol: sy, to_state: ts};
        @(posedge clk);
        while ($urandom_range(99) < gap_pct)
            @(posedge clk);
        start <= 1'b1;
        cmd <= c;
        @(negedge clk);
        while (busy)
            @(negedge clk);
        @(posedge clk);
        pending_rsp.push_back(predict_rsp(c));
        sent++;
        if (op == OP_QUERY)
            queries++;
        start <= 1'b0;
    endtask

    task automatic drain();
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_eps(logic [4:0] v);
        drain();
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= '0;
        pwdata <= {$urandom} & 32'hFFFF_FFE0 | 32'(v);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        eps_sym = v;
        @(posedge clk);
        if (prdata !== {27'd0, v} || pready !== 1'b1)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("register readback: exp %h, got %h", v, prdata);
        end
    endtask

    task automatic test_directed();
        send_cmd(OP_QUERY, 4'd0, 5'd0, 4'd0);
        send_cmd(OP_ADD, 4'd0, 5'd0, 4'd15);
        send_cmd(OP_ADD, 4'd15, 5'd4, 4'd1);
        send_cmd(OP_ADD, 4'd1, 5'd4, 4'd15);
        send_cmd(OP_ADD, 4'd1, 5'd25, 4'd2);
        send_cmd(OP_ADD, 4'd2, 5'd31, 4'd3);
        send_cmd(OP_FINAL, 4'd15, 5'd31, 4'd15);
        send_cmd(OP_QUERY, 4'd15, 5'd25, 4'd0);
        send_cmd(OP_CLOSURE, 4'd0, 5'd0, 4'd0);
        send_cmd(OP_QUERY, 4'd15, 5'd25, 4'd0);
        send_cmd(OP_QUERY, 4'd0, 5'd0, 4'd0);
        send_cmd(OP_QUERY, 4'd1, 5'd4, 4'd0);
        send_cmd(OP_QUERY, 4'd2, 5'd31, 4'd0);
        send_cmd(3'd5, 4'd3, 5'd3, 4'd3);
        send_cmd(3'd6, 4'd15, 5'd31, 4'd15);
        send_cmd(3'd7, 4'd0, 5'd0, 4'd0);
        send_cmd(OP_CLEAR, 4'd0, 5'd0, 4'd0);
        send_cmd(OP_QUERY, 4'd15, 5'd0, 4'd0);
    endtask

    // random automaton build with stray symbols and unused codes, plus queries; eps symbol may sit above NSYM
    task automatic test_random(int n);
        int k;
        logic [4:0] sy;
        k = 0;
        while (k < n)
        begin
            if ($urandom_range(99) < 3)
            begin
                send_cmd(OP_CLEAR, 4'($urandom), 5'($urandom), 4'($urandom));
                k++;
            end
            repeat ($urandom_range(12, 2))
            begin
                sy = ($urandom_range(2) == 0) ? eps_sym : 5'($urandom_range(3));
                if ($urandom_range(19) == 0)
                    sy = 5'($urandom);
                send_cmd(OP_ADD, 4'($urandom), sy, 4'($urandom));
                k++;
            end
            if ($urandom_range(2) == 0)
            begin
                send_cmd(OP_FINAL, 4'($urandom), 5'($urandom), 4'($urandom));
                k++;
            end
            if ($urandom_range(3) != 0)
            begin
                send_cmd(OP_CLOSURE, 4'($urandom), 5'($urandom), 4'($urandom));
                k++;
            end
            repeat ($urandom_range(6, 1))
            begin
                sy = ($urandom_range(4) == 0) ? 5'($urandom) : 5'($urandom_range(3));
                send_cmd(OP_QUERY, 4'($urandom), sy, 4'($urandom));
                k++;
            end
            if ($urandom_range(29) == 0)
            begin
                send_cmd(3'($urandom_range(7, 5)), 4'($urandom), 5'($urandom),
                         4'($urandom));
                k++;
            end
        end
    endtask

    initial
    begin
        clear_nfa();
        eps_sym = EPS_RESET;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        gap_pct = 10;
        test_directed();
        test_random(500);
        write_eps(5'd0);
        gap_pct = 70;
        test_random(400);
        write_eps(5'd31);
        test_random(300);
        write_eps(5'd25);
        gap_pct = 0;
        test_random(300);
        write_eps(5'd4);
        test_random(150);
        drain();
        $display("sent %0d commands (%0d queries) over four epsilon symbol settings",
                 sent, queries);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
